FILE: hw/rtl/dsd_pkg.sv
// Shared types and constants for the dominator set dataflow core.
// Used by the engine, the top level and the testbench.
`default_nettype none
package dsd_pkg;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_STEP_LIMIT = 2'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  localparam logic [6:0] NODE_COUNT_RESET = 7'd64;
  localparam logic [9:0] STEP_LIMIT_RESET = 10'd1000;
  localparam logic [9:0] STEPS_SAT        = 10'h3FF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RFUNC,
    ST_ACTS,
    ST_INIT,
    ST_NFIND,
    ST_NPRED,
    ST_NSCAN,
    ST_NDEC,
    ST_CNT,
    ST_EMIT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic [5:0] node;
    logic       is_root;
    logic       dom;
    logic [9:0] steps;
    logic [6:0] act;
    logic       failed;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dominator_set_dataflow_core.sv
// Load items are taken while the core is idle and may follow back to back. A run item stalls the input
// until its last result word is registered: a setup phase (root function read, active scan,
// dominator row init), sweeps over the nodes with a predecessor scan for each active node other
// than the root, a count phase, then one result word per cycle while out_stall is low.
// Synchronous active-high reset clears control state; memories are undefined until loaded.
// Depends on dsd_pkg and dsd_engine.
`default_nettype none
module dominator_set_dataflow_core import dsd_pkg::*; #(
  parameter int MAX_NODES    = 64,
  parameter int FUNC_ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [5:0]  node_index,
  input  wire logic [15:0] function_id,
  input  wire logic [63:0] pred_mask,
  input  wire logic [5:0]  root_node,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_node,
  output logic             is_root,
  output logic             dominated_by_root,
  output logic [9:0]       step_count,
  output logic [6:0]       active_count,
  output logic             failed,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int CW = $clog2(MAX_NODES) + 1;

  logic [6:0]  node_count;
  logic [9:0]  step_limit;
  logic [CW-1:0] n_eff;
  logic        idle, res_valid, res_take, accept;
  res_t        res;
  logic [31:0] fid_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign accept    = in_valid && !in_stall;
  assign res_take  = res_valid && (!out_valid || !out_stall);
  assign fid_ext   = {16'd0, function_id};

  always_comb begin
    if (node_count == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      step_limit <= STEP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_NODE_COUNT) node_count <= cfg_data[6:0];
      else if (cfg_index == CFG_STEP_LIMIT) step_limit <= cfg_data;
    end
  end

  dsd_engine #(
    .MAX_NODES   (MAX_NODES),
    .FUNC_ID_BITS(FUNC_ID_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .load_we  (accept && func == FUNC_LOAD),
    .load_idx (node_index),
    .load_func(fid_ext[FUNC_ID_BITS-1:0]),
    .load_pred(pred_mask[MAX_NODES-1:0]),
    .run_start(accept && func == FUNC_RUN),
    .root     (root_node),
    .n        (n_eff),
    .limit    (step_limit),
    .idle     (idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_node          <= res.node;
      is_root           <= res.is_root;
      dominated_by_root <= res.dom;
      step_count        <= res.steps;
      active_count      <= res.act;
      failed            <= res.failed;
      last              <= res.last;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dsd_engine.sv
// Dominator engine: graph, function and dominator row memories with the run sequencer.
// Depends on dsd_pkg.
`default_nettype none
module dsd_engine import dsd_pkg::*; #(
  parameter int MAX_NODES    = 64,
  parameter int FUNC_ID_BITS = 16,
  localparam int AW = $clog2(MAX_NODES),
  localparam int CW = AW + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load_we,
  input  wire logic [5:0]              load_idx,
  input  wire logic [FUNC_ID_BITS-1:0] load_func,
  input  wire logic [MAX_NODES-1:0]    load_pred,
  input  wire logic                    run_start,
  input  wire logic [5:0]              root,
  input  wire logic [CW-1:0]           n,
  input  wire logic [9:0]              limit,
  output logic                         idle,
  output logic                         res_valid,
  output res_t                         res,
  input  wire logic                    res_take
);

  logic [MAX_NODES-1:0]    pred_mem [MAX_NODES];
  logic [FUNC_ID_BITS-1:0] func_mem [MAX_NODES];
  logic [MAX_NODES-1:0]    dom_mem  [MAX_NODES];

  state_t state, state_next;

  logic [FUNC_ID_BITS-1:0] func_rd, rfunc;
  logic [MAX_NODES-1:0]    pred_rd, dom_rd;
  logic [AW-1:0]           func_ra;
  logic [5:0]              root_q;
  logic [CW-1:0]           cnt, ci, e, act;
  logic                    vld_q;
  logic [AW-1:0]           idx_q;
  logic [MAX_NODES-1:0]    active, rsel, nmask, preds, inter, old, dbits;
  logic [MAX_NODES-1:0]    fresh, init_row;
  logic                    changed;
  logic [10:0]             steps, steps_inc;
  logic                    diff, over, dom_we, cnt_end;
  logic [AW-1:0]           dom_wa;
  logic [MAX_NODES-1:0]    dom_wd;

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      rsel[k]  = (root_q == 6'(k));
      nmask[k] = (CW'(k) < n);
    end
  end

  assign cnt_end   = (cnt == n);
  assign fresh     = ((preds == '0) ? '0 : inter) | (MAX_NODES'(1) << ci[AW-1:0]);
  assign diff      = (fresh != old);
  assign steps_inc = steps + 11'd1;
  assign over      = (steps_inc > {1'b0, limit});
  assign init_row  = rsel[cnt[AW-1:0]] ? rsel : (active & ~rsel);
  assign func_ra   = (state == ST_IDLE) ? root[AW-1:0] : cnt[AW-1:0];

  always_comb begin
    dom_we = 1'b0;
    dom_wa = cnt[AW-1:0];
    dom_wd = init_row;
    if (state == ST_INIT && !cnt_end) begin
      dom_we = 1'b1;
    end else if (state == ST_NDEC && diff && !over) begin
      dom_we = 1'b1;
      dom_wa = ci[AW-1:0];
      dom_wd = fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      pred_mem[load_idx[AW-1:0]] <= load_pred;
      func_mem[load_idx[AW-1:0]] <= load_func;
    end
    func_rd <= func_mem[func_ra];
    pred_rd <= pred_mem[ci[AW-1:0]];
    if (dom_we) begin
      dom_mem[dom_wa] <= dom_wd;
    end
    dom_rd <= dom_mem[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (run_start) state_next = ST_RFUNC;
      ST_RFUNC: state_next = ST_ACTS;
      ST_ACTS:  if (cnt_end) state_next = ST_INIT;
      ST_INIT:  if (cnt_end) state_next = ST_NFIND;
      ST_NFIND: begin
        if (ci == n) begin
          if (!changed) state_next = ST_CNT;
        end else if (active[ci[AW-1:0]] && !rsel[ci[AW-1:0]]) begin
          state_next = ST_NPRED;
        end
      end
      ST_NPRED: state_next = ST_NSCAN;
      ST_NSCAN: if (cnt_end) state_next = ST_NDEC;
      ST_NDEC:  state_next = (diff && over) ? ST_FAIL : ST_NFIND;
      ST_CNT:   if (cnt_end) state_next = ST_EMIT;
      ST_EMIT:  if (res_take && e == n - CW'(1)) state_next = ST_IDLE;
      ST_FAIL:  if (res_take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    vld_q <= ((state == ST_ACTS) || (state == ST_NSCAN) || (state == ST_CNT)) && !cnt_end;
    idx_q <= cnt[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (run_start) root_q <= root;
      end
      ST_RFUNC: begin
        rfunc  <= func_rd;
        cnt    <= '0;
        active <= '0;
      end
      ST_ACTS: begin
        cnt <= cnt_end ? '0 : cnt + CW'(1);
        if (vld_q && idx_q != '0 && func_rd == rfunc) active[idx_q] <= 1'b1;
      end
      ST_INIT: begin
        cnt <= cnt_end ? '0 : cnt + CW'(1);
        if (cnt_end) begin
          ci      <= '0;
          changed <= 1'b0;
          steps   <= '0;
        end
      end
      ST_NFIND: begin
        if (ci == n) begin
          if (changed) begin
            ci      <= '0;
            changed <= 1'b0;
          end else begin
            cnt   <= '0;
            act   <= '0;
            dbits <= '0;
          end
        end else if (!(active[ci[AW-1:0]] && !rsel[ci[AW-1:0]])) begin
          ci <= ci + CW'(1);
        end
      end
      ST_NPRED: begin
        preds <= pred_rd & nmask;
        inter <= '1;
        cnt   <= '0;
      end
      ST_NSCAN: begin
        if (!cnt_end) cnt <= cnt + CW'(1);
        if (vld_q) begin
          if (idx_q == ci[AW-1:0]) old <= dom_rd;
          if (preds[idx_q]) inter <= inter & (active[idx_q] ? dom_rd : '0);
        end
      end
      ST_NDEC: begin
        if (diff) begin
          steps <= steps_inc;
          if (!over) changed <= 1'b1;
        end
        ci <= ci + CW'(1);
      end
      ST_CNT: begin
        if (!cnt_end) cnt <= cnt + CW'(1);
        if (vld_q) begin
          dbits[idx_q] <= active[idx_q] && (|(dom_rd & rsel));
          act <= act + CW'(active[idx_q] && (|(dom_rd & rsel)));
        end
        e <= '0;
      end
      ST_EMIT: begin
        if (res_take) e <= e + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idle      = (state == ST_IDLE);
    res_valid = (state == ST_EMIT) || (state == ST_FAIL);
    res       = '0;
    if (state == ST_FAIL) begin
      res.steps  = steps[10] ? STEPS_SAT : steps[9:0];
      res.failed = 1'b1;
      res.last   = 1'b1;
    end else begin
      res.node    = 6'(e);
      res.is_root = rsel[e[AW-1:0]];
      res.dom     = dbits[e[AW-1:0]];
      res.steps   = steps[9:0];
      res.act     = 7'(act);
      res.last    = (e == n - CW'(1));
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dsd_checker.sv
// Port-level checks on the result channel of the dominator set dataflow core.
// Bound to dominator_set_dataflow_core; no package dependency.
`default_nettype none
module dsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] out_node,
  input wire logic       is_root,
  input wire logic       dominated_by_root,
  input wire logic [6:0] active_count,
  input wire logic       failed,
  input wire logic       last
);

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> last)
    else $error("Failure word without last.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> out_node == 6'd0 && !is_root && !dominated_by_root
      && active_count == 7'd0)
    else $error("Failure word carries node data.");

  a_dom_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !failed && dominated_by_root |-> active_count != 7'd0)
    else $error("Dominated node with zero active count.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_node) && $stable(last))
    else $error("Stalled word changed.");

endmodule

bind dominator_set_dataflow_core dsd_checker u_dsd_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_node         (out_node),
  .is_root          (is_root),
  .dominated_by_root(dominated_by_root),
  .active_count     (active_count),
  .failed           (failed),
  .last             (last)
);
`default_nettype wire

FILE: bench/dominator_set_dataflow_core_tb.sv
// Self-checking testbench for the dominator set dataflow core.
// It loads node graphs, runs dominator analyses under several settings and idling mixes,
// and compares every result word with its own prediction. Depends on dsd_pkg and the core.
`timescale 1ns / 100ps
module dominator_set_dataflow_core_tb;
  import dsd_pkg::*;

  class dom_scoreboard;
    logic [63:0] pred_row [64];
    logic [15:0] node_fn [64];
    int unsigned node_cfg = 64;
    int unsigned limit_cfg = 1000;
    res_t        awaited [$];
    int          errors;
    int          runs;
    int          fails_seen;
    int          words_seen;

    function void note_item(logic f, logic [5:0] idx, logic [15:0] fid, logic [63:0] pm,
                            logic [5:0] root);
      int unsigned n;
      int unsigned steps;
      int unsigned act;
      logic [63:0] nmask;
      logic [63:0] active;
      logic [63:0] rows [64];
      logic [63:0] preds;
      logic [63:0] inter;
      logic [63:0] fresh;
      logic        changed;
      logic        fail;
      res_t        r;
      if (f == FUNC_LOAD) begin
        node_fn[idx] = fid;
        pred_row[idx] = pm;
        return;
      end
      runs++;
      n = (node_cfg < 1) ? 1 : (node_cfg > 64) ? 64 : node_cfg;
      nmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      active = '0;
      for (int i = 1; i < n; i++)
        if (node_fn[i] == node_fn[root]) active[i] = 1'b1;
      for (int i = 0; i < 64; i++) begin
        if (!active[i]) rows[i] = '0;
        else if (i == root) rows[i] = 64'd1 << root;
        else rows[i] = active & ~(64'd1 << root);
      end
      steps = 0;
      changed = 1'b1;
      fail = 1'b0;
      while (changed && !fail) begin
        changed = 1'b0;
        for (int i = 1; i < n; i++) begin
          if (!active[i] || i == root) continue;
          preds = pred_row[i] & nmask;
          inter = (preds == '0) ? '0 : '1;
          for (int j = 0; j < n; j++)
            if (preds[j]) inter &= active[j] ? rows[j] : '0;
          fresh = inter | (64'd1 << i);
          if (fresh != rows[i]) begin
            steps++;
            if (steps > limit_cfg) begin
              fail = 1'b1;
              break;
            end
            rows[i] = fresh;
            changed = 1'b1;
          end
        end
      end
      if (fail) begin
        r = '0;
        r.steps = (steps > 1023) ? STEPS_SAT : 10'(steps);
        r.failed = 1'b1;
        r.last = 1'b1;
        awaited = {awaited, r};
        return;
      end
      act = 0;
      for (int i = 0; i < n; i++)
        if (active[i] && rows[i][root]) act++;
      for (int i = 0; i < n; i++) begin
        r.node = 6'(i);
        r.is_root = (i == root);
        r.dom = active[i] && rows[i][root];
        r.steps = 10'(steps);
        r.act = 7'(act);
        r.failed = 1'b0;
        r.last = (i + 1 == n);
        awaited = {awaited, r};
      end
    endfunction

    function void check_word(res_t got);
      res_t exp;
      words_seen++;
      if (got.failed) fails_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result word for node %0d", got.node);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.node !== exp.node) begin
        $error("out_node expected %0d got %0d", exp.node, got.node); errors++;
      end
      if (got.is_root !== exp.is_root) begin
        $error("is_root expected %0d got %0d", exp.is_root, got.is_root); errors++;
      end
      if (got.dom !== exp.dom) begin
        $error("dominated_by_root expected %0d got %0d", exp.dom, got.dom); errors++;
      end
      if (got.steps !== exp.steps) begin
        $error("step_count expected %0d got %0d", exp.steps, got.steps); errors++;
      end
      if (got.act !== exp.act) begin
        $error("active_count expected %0d got %0d", exp.act, got.act); errors++;
      end
      if (got.failed !== exp.failed) begin
        $error("failed expected %0d got %0d", exp.failed, got.failed); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last expected %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_LOAD;
  logic [5:0]  node_index = '0;
  logic [15:0] function_id = '0;
  logic [63:0] pred_mask = '0;
  logic [5:0]  root_node = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_node;
  logic        is_root;
  logic        dominated_by_root;
  logic [9:0]  step_count;
  logic [6:0]  active_count;
  logic        failed;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  dom_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;

  dominator_set_dataflow_core i_dut (
    .clk, .rst, .in_valid, .in_stall, .func, .node_index, .function_id, .pred_mask,
    .root_node, .out_valid, .out_stall, .out_node, .is_root, .dominated_by_root,
    .step_count, .active_count, .failed, .last, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word({out_node, is_root, dominated_by_root, step_count, active_count,
                     failed, last});
    end
  end

  task automatic send_word(logic f, logic [5:0] idx, logic [15:0] fid, logic [63:0] pm,
                           logic [5:0] root);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    node_index <= idx;
    function_id <= fid;
    pred_mask <= pm;
    root_node <= root;
    do @(posedge clk); while (in_stall);
    sb.note_item(f, idx, fid, pm, root);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NODE_COUNT) sb.node_cfg = val & 10'h7F;
    else if (idx == CFG_STEP_LIMIT) sb.limit_cfg = val;
  endtask

  task automatic settle_and_configure(logic [9:0] nodes, logic [9:0] lim);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(CFG_NODE_COUNT, nodes);
    write_reg(CFG_STEP_LIMIT, lim);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] sparse_preds(int span);
    logic [63:0] m;
    m = '0;
    if ($urandom_range(0, 9) == 0) return {$urandom(), $urandom()};
    repeat ($urandom_range(0, 3)) m[$urandom_range(0, span - 1)] = 1'b1;
    return m;
  endfunction

  function automatic logic [15:0] pick_fn();
    if ($urandom_range(0, 19) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 2));
  endfunction

  task automatic random_phase(int count, int span);
    int lo;
    for (int k = 0; k < count; k++) begin
      lo = ($urandom_range(0, 9) == 0) ? 64 : span;
      if ($urandom_range(0, 99) < 65)
        send_word(FUNC_LOAD, 6'($urandom_range(0, lo - 1)), pick_fn(), sparse_preds(lo),
                  6'($urandom()));
      else
        send_word(FUNC_RUN, 6'($urandom()), 16'($urandom()), {$urandom(), $urandom()},
                  6'($urandom_range(0, lo - 1)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    settle_and_configure(10'd64, 10'd1000);
    for (int i = 0; i < 64; i++)
      send_word(FUNC_LOAD, 6'(i), pick_fn(),
                sparse_preds(16) | (i > 1 ? 64'd1 << (i - 1) : 64'd0), 6'($urandom()));
    send_word(FUNC_LOAD, 6'd0, 16'hFFFF, '1, 6'd0);
    send_word(FUNC_LOAD, 6'd63, 16'h0000, '1, 6'd63);
    send_word(FUNC_LOAD, 6'd1, 16'h0000, '0, 6'd0);
    send_word(FUNC_LOAD, 6'd2, 16'h0000, 64'd2, 6'd0);
    send_word(FUNC_LOAD, 6'd3, 16'h0000, 64'd1 | 64'd4, 6'd0);
    send_word(FUNC_LOAD, 6'd4, 16'h0001, 64'd8, 6'd0);
    send_word(FUNC_LOAD, 6'd5, 16'h0000, 64'd8 | 64'd16 | 64'd4, 6'd0);
    send_word(FUNC_RUN, 6'h3F, 16'hFFFF, '1, 6'd1);
    send_word(FUNC_RUN, 6'd0, 16'd0, '0, 6'd2);
    send_word(FUNC_RUN, 6'd0, 16'd0, '0, 6'd0);
    send_word(FUNC_RUN, 6'd0, 16'd0, '0, 6'd63);

    settle_and_configure(10'd8, 10'd1);
    send_word(FUNC_RUN, 6'd0, 16'd0, '0, 6'd1);
    send_word(FUNC_RUN, 6'd0, 16'd0, '0, 6'd9);
    send_idle_pct = 73;
    random_phase(35, 8);

    settle_and_configure(10'd16, 10'd1000);
    send_idle_pct = 0;
    stall_pct = 73;
    random_phase(40, 16);

    settle_and_configure(10'd12, 10'd5);
    send_idle_pct = 19;
    stall_pct = 19;
    random_phase(35, 12);

    settle_and_configure(10'd0, 10'd1023);
    random_phase(12, 4);
    settle_and_configure(10'd1, 10'd3);
    random_phase(12, 4);
    settle_and_configure(10'd127, 10'd1000);
    send_idle_pct = 0;
    stall_pct = 0;
    random_phase(6, 16);

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d analyses and checked %0d result words (%0d step limit failures).",
             sb.runs, sb.words_seen, sb.fails_seen);
    $display("Settings covered node counts 0 to 127 and step limits 1 to 1023.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dsd_pkg.sv
hw/rtl/dsd_engine.sv
hw/rtl/dominator_set_dataflow_core.sv
hw/rtl/dsd_checker.sv
bench/dominator_set_dataflow_core_tb.sv
